@@ src/adcrr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcrr_pkg
// Shared types and codes for the round-robin ADC scan sequencer.
// ----------------------------------------------------------------------------
package adcrr_pkg;

  // sequencer phase codes (code 3 is unused and runs as select)
  localparam logic [1:0] PH_SELECT = 2'd0;
  localparam logic [1:0] PH_ACQ    = 2'd1;
  localparam logic [1:0] PH_CONV   = 2'd2;

  // register indexes on the APB port
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_CHANNEL_MAP   = 2'd1;
  localparam logic [1:0] REG_ACQ_TICKS     = 2'd2;

  localparam logic [7:0] ACQ_TICKS_RST = 8'd1;
  localparam logic [7:0] TICK_MAX      = 8'hFF;

  // one result beat
  typedef struct packed {
    logic [3:0] channel_select;
    logic       channel_set;
    logic       start_conversion;
    logic       sample_stored;
    logic [2:0] stored_index;
    logic [7:0] read_data;
  } res_t;

endpackage

@@ src/adc_round_robin_scan_sequencer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_round_robin_scan_sequencer_unit
// Round-robin ADC scan sequencer: select, acquire and convert phases per
// scan entry, with a small sample store read back by read items.
// ----------------------------------------------------------------------------
// A result beat is registered in the output register, or in the skid register
// while the output beat is held. Throughput: one beat per cycle while in_stall
//   is low; phase, index and tick counter update in a single pass at accept,
//   and an output register plus a skid register decouple the two channels.
// Reset (rst_n, synchronous): phase select, index 0, tick count 0, sample
//   store all zero, channel_count 0, channel_map 0, acq_ticks 1.
module adc_round_robin_scan_sequencer_unit #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic        in_tick_pulse,
  input  logic        in_conv_busy,
  input  logic [7:0]  in_adc_high,
  input  logic [2:0]  in_read_index,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_channel_select,
  output logic        out_channel_set,
  output logic        out_start_conversion,
  output logic        out_sample_stored,
  output logic [2:0]  out_stored_index,
  output logic [7:0]  out_read_data
);

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [4:0] MAX_CNT = 5'(MAX_CHANNELS);

  // configuration
  logic [3:0]  channel_count_r;
  logic [31:0] channel_map_r;
  logic [7:0]  acq_ticks_r;
  logic        cfg_wr;

  // sequencer state
  logic [1:0]       phase_r, phase_nxt;
  logic [IDX_W-1:0] cur_idx_r, cur_idx_nxt;
  logic [7:0]       tick_cnt_r, tick_cnt_nxt;
  logic [3:0]       mux_r, mux_nxt;
  logic [7:0]       store_r [MAX_CHANNELS];

  // output stage
  logic             out_valid_r;
  adcrr_pkg::res_t  out_r;
  logic             skid_vld_r;
  adcrr_pkg::res_t  skid_r;

  logic             acc_in;
  logic             out_free;
  adcrr_pkg::res_t  res;
  logic             store_wr;

  logic [4:0]       count;
  logic [IDX_W-1:0] ci;
  logic [4:0]       ci_ext;
  logic [IDX_W-1:0] ci_inc;
  logic [4:0]       ci_inc_ext;
  logic [7:0]       tick_inc;
  logic [4:0]       ridx_ext;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      adcrr_pkg::REG_CHANNEL_COUNT: prdata = {28'd0, channel_count_r};
      adcrr_pkg::REG_CHANNEL_MAP:   prdata = channel_map_r;
      adcrr_pkg::REG_ACQ_TICKS:     prdata = {24'd0, acq_ticks_r};
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r <= '0;
      channel_map_r   <= '0;
      acq_ticks_r     <= adcrr_pkg::ACQ_TICKS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        adcrr_pkg::REG_CHANNEL_COUNT: channel_count_r <= pwdata[3:0];
        adcrr_pkg::REG_CHANNEL_MAP:   channel_map_r   <= pwdata;
        adcrr_pkg::REG_ACQ_TICKS:     acq_ticks_r     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign in_stall = skid_vld_r;
  assign acc_in   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // single-pass sequencer step
  always_comb begin
    count = ({1'b0, channel_count_r} > MAX_CNT) ? MAX_CNT : {1'b0, channel_count_r};
    ci    = (5'(cur_idx_r) >= count) ? '0 : cur_idx_r;
    ci_ext     = 5'(ci);
    ci_inc     = ci + 1'b1;
    ci_inc_ext = ci_ext + 5'd1;
    tick_inc   = (in_tick_pulse && tick_cnt_r != adcrr_pkg::TICK_MAX) ?
                 tick_cnt_r + 8'd1 : tick_cnt_r;
    ridx_ext   = 5'(in_read_index);

    phase_nxt    = phase_r;
    cur_idx_nxt  = cur_idx_r;
    tick_cnt_nxt = tick_cnt_r;
    mux_nxt      = mux_r;
    store_wr     = 1'b0;

    res                  = '0;
    res.stored_index     = 3'(cur_idx_r);

    if (in_mode) begin
      if (ridx_ext < count && ridx_ext < MAX_CNT) begin
        res.read_data = store_r[ridx_ext[IDX_W-1:0]];
      end
    end else if (count != 5'd0) begin
      cur_idx_nxt      = ci;
      res.stored_index = ci_ext[2:0];
      case (phase_r)
        adcrr_pkg::PH_ACQ: begin
          tick_cnt_nxt = tick_inc;
          if (tick_inc >= acq_ticks_r) begin
            res.start_conversion = 1'b1;
            phase_nxt            = adcrr_pkg::PH_CONV;
          end
        end
        adcrr_pkg::PH_CONV: begin
          tick_cnt_nxt = tick_inc;
          if (!in_conv_busy) begin
            store_wr          = 1'b1;
            res.sample_stored = 1'b1;
            cur_idx_nxt       = (ci_inc_ext >= count) ? '0 : ci_inc;
            phase_nxt         = adcrr_pkg::PH_SELECT;
          end
        end
        default: begin
          // select (and the unused code)
          mux_nxt         = (ci_ext >= 5'd8) ? 4'd0 : channel_map_r[ci_ext[2:0]*4 +: 4];
          res.channel_set = 1'b1;
          tick_cnt_nxt    = '0;
          phase_nxt       = adcrr_pkg::PH_ACQ;
        end
      endcase
    end
    res.channel_select = mux_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= adcrr_pkg::PH_SELECT;
      cur_idx_r  <= '0;
      tick_cnt_r <= '0;
      mux_r      <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        store_r[i] <= '0;
      end
    end else if (acc_in) begin
      phase_r    <= phase_nxt;
      cur_idx_r  <= cur_idx_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      mux_r      <= mux_nxt;
      if (store_wr) begin
        store_r[ci] <= in_adc_high;
      end
    end
  end

  // output register with skid: a new beat lands in the skid only while the
  // output beat is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= skid_vld_r || acc_in;
      skid_vld_r  <= 1'b0;
    end else if (acc_in) begin
      skid_vld_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_vld_r ? skid_r : res;
    end
    if (!out_free && acc_in) begin
      skid_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_channel_select   = out_r.channel_select;
  assign out_channel_set      = out_r.channel_set;
  assign out_start_conversion = out_r.start_conversion;
  assign out_sample_stored    = out_r.sample_stored;
  assign out_stored_index     = out_r.stored_index;
  assign out_read_data        = out_r.read_data;

  // assertions
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_valid_r)
    else $error("skid holds a beat while the output register is empty");

  a_start_to_conv: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && res.start_conversion |=> phase_r == adcrr_pkg::PH_CONV)
    else $error("conversion start did not move to convert phase");

  a_set_to_acq: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && res.channel_set |=> phase_r == adcrr_pkg::PH_ACQ && tick_cnt_r == 8'd0)
    else $error("channel select did not enter acquire with cleared ticks");

  a_store_to_select: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && res.sample_stored |=> phase_r == adcrr_pkg::PH_SELECT)
    else $error("stored sample did not return to select phase");

  a_step_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in |-> $onehot0({res.channel_set, res.start_conversion, res.sample_stored}))
    else $error("more than one phase flag in one beat");

endmodule
